>>> sv/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants, register map, wall case codes and configuration types
// for the wall centering PID unit.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int DIST_BITS      = 11;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W     = 12;
  localparam int CORR_W     = 8;
  localparam int PWM_W      = 8;
  localparam int CASE_W     = 3;
  localparam int ESUM_W     = 9;
  localparam int HELD_W     = 9;
  localparam int SUM_LIMIT  = 200;
  localparam int PWM_MAX    = 255;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_CORRECTION = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_TARGET  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VALID_MIN      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_VALID_MAX      = 3'd7;

  localparam logic [CASE_W-1:0] CASE_DISABLED  = 3'd0;
  localparam logic [CASE_W-1:0] CASE_HOLD      = 3'd1;
  localparam logic [CASE_W-1:0] CASE_BOTH_OPEN = 3'd2;
  localparam logic [CASE_W-1:0] CASE_LEFT_OPEN = 3'd3;
  localparam logic [CASE_W-1:0] CASE_RIGHT_OPEN = 3'd4;
  localparam logic [CASE_W-1:0] CASE_TWO_WALLS = 3'd5;

  localparam logic              RST_ENABLE         = 1'b1;
  localparam logic [GAIN_W-1:0] RST_GAIN_P         = 12'd512;
  localparam logic [GAIN_W-1:0] RST_GAIN_I         = 12'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN_D         = 12'd128;
  localparam logic [CORR_W-1:0] RST_MAX_CORRECTION = 8'd60;
  localparam int                RST_CENTER_TARGET  = 90;
  localparam int                RST_VALID_MIN      = 20;
  localparam int                RST_VALID_MAX      = 400;

  typedef struct packed {
    logic              enable;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [CORR_W-1:0] max_correction;
  } ctrl_cfg_t;

endpackage

>>> sv/wcp_in_if.sv
// ----------------------------------------------------------------------------
// wcp_in_if
// Request channel carrying side distances, opening limits and base drive.
// ----------------------------------------------------------------------------
interface wcp_in_if
  import wcp_pkg::*;
#(
  parameter int DistBits = DIST_BITS
);
  logic                valid;
  logic                ready;
  logic [DistBits-1:0] left_distance;
  logic [DistBits-1:0] right_distance;
  logic [DistBits-1:0] left_open_limit;
  logic [DistBits-1:0] right_open_limit;
  logic [PWM_W-1:0]    base_pwm;

  modport source (
    output valid, left_distance, right_distance, left_open_limit,
           right_open_limit, base_pwm,
    input  ready
  );

  modport sink (
    input  valid, left_distance, right_distance, left_open_limit,
           right_open_limit, base_pwm,
    output ready
  );
endinterface

>>> sv/wcp_out_if.sv
// ----------------------------------------------------------------------------
// wcp_out_if
// Result channel carrying both wheel drive levels and the wall case code.
// ----------------------------------------------------------------------------
interface wcp_out_if
  import wcp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [PWM_W-1:0]  left_pwm;
  logic [PWM_W-1:0]  right_pwm;
  logic [CASE_W-1:0] wall_case;

  modport source (
    output valid, left_pwm, right_pwm, wall_case,
    input  ready
  );

  modport sink (
    input  valid, left_pwm, right_pwm, wall_case,
    output ready
  );
endinterface

>>> sv/wcp_regs.sv
// ----------------------------------------------------------------------------
// wcp_regs
// APB-style configuration register file with a state clear pulse on any
// write to the enable register.
// ----------------------------------------------------------------------------
module wcp_regs
  import wcp_pkg::*;
#(
  parameter int DistBits = DIST_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output ctrl_cfg_t             ctrl_cfg_o,
  output logic [DistBits-1:0]   center_target_o,
  output logic [DistBits-1:0]   valid_min_o,
  output logic [DistBits-1:0]   valid_max_o,
  output logic                  clear_o
);

  ctrl_cfg_t             ctrl_q;
  logic [DistBits-1:0]   center_q;
  logic [DistBits-1:0]   vmin_q;
  logic [DistBits-1:0]   vmax_q;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.enable         <= RST_ENABLE;
      ctrl_q.gain_p         <= RST_GAIN_P;
      ctrl_q.gain_i         <= RST_GAIN_I;
      ctrl_q.gain_d         <= RST_GAIN_D;
      ctrl_q.max_correction <= RST_MAX_CORRECTION;
      center_q              <= DistBits'(RST_CENTER_TARGET);
      vmin_q                <= DistBits'(RST_VALID_MIN);
      vmax_q                <= DistBits'(RST_VALID_MAX);
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE:         ctrl_q.enable         <= pwdata[0];
        REG_GAIN_P:         ctrl_q.gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:         ctrl_q.gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:         ctrl_q.gain_d         <= pwdata[GAIN_W-1:0];
        REG_MAX_CORRECTION: ctrl_q.max_correction <= pwdata[CORR_W-1:0];
        REG_CENTER_TARGET:  center_q              <= pwdata[DistBits-1:0];
        REG_VALID_MIN:      vmin_q                <= pwdata[DistBits-1:0];
        REG_VALID_MAX:      vmax_q                <= pwdata[DistBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:         prdata = APB_DATA_W'(ctrl_q.enable);
      REG_GAIN_P:         prdata = APB_DATA_W'(ctrl_q.gain_p);
      REG_GAIN_I:         prdata = APB_DATA_W'(ctrl_q.gain_i);
      REG_GAIN_D:         prdata = APB_DATA_W'(ctrl_q.gain_d);
      REG_MAX_CORRECTION: prdata = APB_DATA_W'(ctrl_q.max_correction);
      REG_CENTER_TARGET:  prdata = APB_DATA_W'(center_q);
      REG_VALID_MIN:      prdata = APB_DATA_W'(vmin_q);
      REG_VALID_MAX:      prdata = APB_DATA_W'(vmax_q);
      default:            prdata = '0;
    endcase
  end

  assign clear_o         = wr_en && (idx == REG_ENABLE);
  assign ctrl_cfg_o      = ctrl_q;
  assign center_target_o = center_q;
  assign valid_min_o     = vmin_q;
  assign valid_max_o     = vmax_q;

endmodule

>>> sv/wcp_datapath.sv
// ----------------------------------------------------------------------------
// wcp_datapath
// Single-pass wall case selection, PID sum with clamps, and wheel drive
// saturation, computed from one registered request and the current state.
// ----------------------------------------------------------------------------
module wcp_datapath
  import wcp_pkg::*;
#(
  parameter int DistBits     = DIST_BITS,
  parameter int GainFracBits = GAIN_FRAC_BITS
) (
  input  ctrl_cfg_t                  ctrl_cfg_i,
  input  logic [DistBits-1:0]        center_target_i,
  input  logic [DistBits-1:0]        valid_min_i,
  input  logic [DistBits-1:0]        valid_max_i,
  input  logic [DistBits-1:0]        left_distance_i,
  input  logic [DistBits-1:0]        right_distance_i,
  input  logic [DistBits-1:0]        left_open_limit_i,
  input  logic [DistBits-1:0]        right_open_limit_i,
  input  logic [PWM_W-1:0]           base_pwm_i,
  input  logic signed [ESUM_W-1:0]   error_sum_i,
  input  logic signed [DistBits:0]   last_error_i,
  input  logic signed [HELD_W-1:0]   held_i,
  output logic                       update_o,
  output logic signed [ESUM_W-1:0]   error_sum_o,
  output logic signed [DistBits:0]   last_error_o,
  output logic signed [HELD_W-1:0]   held_o,
  output logic [PWM_W-1:0]           left_pwm_o,
  output logic [PWM_W-1:0]           right_pwm_o,
  output logic [CASE_W-1:0]          wall_case_o
);

  localparam int EW = DistBits + 1;
  localparam int SW = DistBits + 2;
  localparam int AW = GAIN_W + SW + 3;

  logic                 outlier;
  logic                 open_l;
  logic                 open_r;
  logic signed [EW-1:0] err;
  logic [CASE_W-1:0]    pid_case;
  logic signed [SW-1:0] esum_raw;
  logic signed [SW-1:0] esum_lim;
  logic signed [ESUM_W-1:0] esum_new;
  logic signed [AW-1:0] gp_x;
  logic signed [AW-1:0] gi_x;
  logic signed [AW-1:0] gd_x;
  logic signed [AW-1:0] e_x;
  logic signed [AW-1:0] s_x;
  logic signed [AW-1:0] d_x;
  logic signed [AW-1:0] pid_sum;
  logic signed [AW-1:0] lim;
  logic signed [AW-1:0] pid_clamped;
  logic signed [AW-1:0] pid_abs;
  logic [HELD_W-1:0]    mag;
  logic signed [AW-1:0] corr;
  logic signed [AW-1:0] base_s;

  function automatic logic [PWM_W-1:0] drive_level(input logic signed [AW-1:0] lvl);
    logic signed [AW-1:0] whole;
    whole = lvl >>> GainFracBits;
    if (lvl <= 0) begin
      drive_level = '0;
    end else if (whole > AW'(PWM_MAX)) begin
      drive_level = PWM_W'(PWM_MAX);
    end else begin
      drive_level = whole[PWM_W-1:0];
    end
  endfunction

  assign outlier = (left_distance_i < valid_min_i) || (left_distance_i > valid_max_i) ||
                   (right_distance_i < valid_min_i) || (right_distance_i > valid_max_i);
  assign open_l  = left_distance_i > left_open_limit_i;
  assign open_r  = right_distance_i > right_open_limit_i;

  always_comb begin
    if (open_l && open_r) begin
      err      = '0;
      pid_case = CASE_BOTH_OPEN;
    end else if (open_l) begin
      err      = $signed({1'b0, center_target_i}) - $signed({1'b0, right_distance_i});
      pid_case = CASE_LEFT_OPEN;
    end else if (open_r) begin
      err      = $signed({1'b0, left_distance_i}) - $signed({1'b0, center_target_i});
      pid_case = CASE_RIGHT_OPEN;
    end else begin
      err      = $signed({1'b0, left_distance_i}) - $signed({1'b0, right_distance_i});
      pid_case = CASE_TWO_WALLS;
    end
  end

  always_comb begin
    esum_raw = SW'(error_sum_i) + SW'(err);
    if (esum_raw > $signed(SW'(SUM_LIMIT))) begin
      esum_lim = $signed(SW'(SUM_LIMIT));
    end else if (esum_raw < -$signed(SW'(SUM_LIMIT))) begin
      esum_lim = -$signed(SW'(SUM_LIMIT));
    end else begin
      esum_lim = esum_raw;
    end
    esum_new = esum_lim[ESUM_W-1:0];
  end

  always_comb begin
    gp_x    = $signed(AW'(ctrl_cfg_i.gain_p));
    gi_x    = $signed(AW'(ctrl_cfg_i.gain_i));
    gd_x    = $signed(AW'(ctrl_cfg_i.gain_d));
    e_x     = AW'(err);
    s_x     = AW'(esum_new);
    d_x     = AW'(err) - AW'(last_error_i);
    pid_sum = gp_x * e_x + gi_x * s_x + gd_x * d_x;
    lim     = $signed(AW'({ctrl_cfg_i.max_correction, {GainFracBits{1'b0}}}));
    if (pid_sum > lim) begin
      pid_clamped = lim;
    end else if (pid_sum < -lim) begin
      pid_clamped = -lim;
    end else begin
      pid_clamped = pid_sum;
    end
    pid_abs = pid_clamped[AW-1] ? -pid_clamped : pid_clamped;
    mag     = HELD_W'(pid_abs >>> GainFracBits);
  end

  always_comb begin
    base_s = $signed(AW'({base_pwm_i, {GainFracBits{1'b0}}}));
    corr   = outlier ? (AW'(held_i) <<< GainFracBits) : pid_clamped;
  end

  always_comb begin
    update_o     = ctrl_cfg_i.enable && !outlier;
    error_sum_o  = esum_new;
    last_error_o = err;
    held_o       = pid_clamped[AW-1] ? -$signed(mag) : $signed(mag);
    if (!ctrl_cfg_i.enable) begin
      left_pwm_o  = base_pwm_i;
      right_pwm_o = base_pwm_i;
      wall_case_o = CASE_DISABLED;
    end else begin
      left_pwm_o  = drive_level(base_s - corr);
      right_pwm_o = drive_level(base_s + corr);
      wall_case_o = outlier ? CASE_HOLD : pid_case;
    end
  end

endmodule

>>> sv/wall_centering_pid_unit.sv
// ----------------------------------------------------------------------------
// wall_centering_pid_unit
// Wall centering PID controller for a two-wheel drive with integral clamp,
// outlier hold and saturated wheel drive outputs.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake       Carries
// in_ch     in   valid/ready     side distances, open limits, base drive
// out_ch    out  valid/ready     left and right drive, wall case code
// apb       in   psel/penable    configuration registers at 4*index
//
// A request is taken into an input register, computed in one pass and
// stored in a result register, so one request per cycle is sustained
// while the result channel is not stalled.
// PID state moves only on a registered, enabled, in-range result or a clear.
// A stalled result holds while the input register still accepts one more.
// Reset clears the handshake state and the PID state; no clearing pass.
// ----------------------------------------------------------------------------
module wall_centering_pid_unit
  import wcp_pkg::*;
#(
  parameter int DistBits     = DIST_BITS,
  parameter int GainFracBits = GAIN_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wcp_in_if.sink                in_ch,
  wcp_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_cfg_t                ctrl_cfg;
  logic [DistBits-1:0]      center_target;
  logic [DistBits-1:0]      valid_min;
  logic [DistBits-1:0]      valid_max;
  logic                     clear;

  logic                     in_valid_q;
  logic [DistBits-1:0]      left_q;
  logic [DistBits-1:0]      right_q;
  logic [DistBits-1:0]      lim_l_q;
  logic [DistBits-1:0]      lim_r_q;
  logic [PWM_W-1:0]         base_q;

  logic                     out_valid_q;
  logic [PWM_W-1:0]         left_pwm_q;
  logic [PWM_W-1:0]         right_pwm_q;
  logic [CASE_W-1:0]        wall_case_q;

  logic signed [ESUM_W-1:0] esum_q;
  logic signed [DistBits:0] last_err_q;
  logic signed [HELD_W-1:0] held_q;

  logic                     update;
  logic signed [ESUM_W-1:0] esum_d;
  logic signed [DistBits:0] last_err_d;
  logic signed [HELD_W-1:0] held_d;
  logic [PWM_W-1:0]         left_pwm_d;
  logic [PWM_W-1:0]         right_pwm_d;
  logic [CASE_W-1:0]        wall_case_d;
  logic                     advance;

  wcp_regs #(
    .DistBits(DistBits)
  ) u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ctrl_cfg_o     (ctrl_cfg),
    .center_target_o(center_target),
    .valid_min_o    (valid_min),
    .valid_max_o    (valid_max),
    .clear_o        (clear)
  );

  wcp_datapath #(
    .DistBits    (DistBits),
    .GainFracBits(GainFracBits)
  ) u_datapath (
    .ctrl_cfg_i        (ctrl_cfg),
    .center_target_i   (center_target),
    .valid_min_i       (valid_min),
    .valid_max_i       (valid_max),
    .left_distance_i   (left_q),
    .right_distance_i  (right_q),
    .left_open_limit_i (lim_l_q),
    .right_open_limit_i(lim_r_q),
    .base_pwm_i        (base_q),
    .error_sum_i       (esum_q),
    .last_error_i      (last_err_q),
    .held_i            (held_q),
    .update_o          (update),
    .error_sum_o       (esum_d),
    .last_error_o      (last_err_d),
    .held_o            (held_d),
    .left_pwm_o        (left_pwm_d),
    .right_pwm_o       (right_pwm_d),
    .wall_case_o       (wall_case_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      left_q  <= in_ch.left_distance;
      right_q <= in_ch.right_distance;
      lim_l_q <= in_ch.left_open_limit;
      lim_r_q <= in_ch.right_open_limit;
      base_q  <= in_ch.base_pwm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      left_pwm_q  <= left_pwm_d;
      right_pwm_q <= right_pwm_d;
      wall_case_q <= wall_case_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q     <= '0;
      last_err_q <= '0;
      held_q     <= '0;
    end else if (clear) begin
      esum_q     <= '0;
      last_err_q <= '0;
      held_q     <= '0;
    end else if (advance && update) begin
      esum_q     <= esum_d;
      last_err_q <= last_err_d;
      held_q     <= held_d;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.left_pwm  = left_pwm_q;
  assign out_ch.right_pwm = right_pwm_q;
  assign out_ch.wall_case = wall_case_q;

endmodule
